[rtl/core/tcb_pkg.sv]
// tcb_pkg: shared types, constants and the sgr colour table for the text cell buffer
// depends on nothing
`default_nettype none
package tcb_pkg;

  // default grid bounds
  localparam int unsigned MaxColumnsDef = 128;
  localparam int unsigned MaxRowsDef    = 64;

  // command codes
  localparam logic [3:0] CmdPrint     = 4'd0;
  localparam logic [3:0] CmdClearCell = 4'd1;
  localparam logic [3:0] CmdEraseLine = 4'd2;
  localparam logic [3:0] CmdEraseScr  = 4'd3;
  localparam logic [3:0] CmdScrollUp  = 4'd4;
  localparam logic [3:0] CmdSetFg     = 4'd5;
  localparam logic [3:0] CmdSetBg     = 4'd6;
  localparam logic [3:0] CmdResetCol  = 4'd7;
  localparam logic [3:0] CmdReadCell  = 4'd8;

  // erase line modes
  localparam logic [1:0] ModeToEnd   = 2'd0;
  localparam logic [1:0] ModeToStart = 2'd1;
  localparam logic [1:0] ModeWhole   = 2'd2;
  localparam logic [1:0] ModeNone    = 2'd3;

  // configuration register indexes
  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;

  // colours and reset values
  localparam logic [31:0] ColorWhite = 32'hFFFF_FFFF;
  localparam logic [31:0] ColorBlack = 32'h0000_0000;
  localparam logic [7:0]  ColsReset  = 8'd80;
  localparam logic [6:0]  RowsReset  = 7'd25;
  localparam logic [7:0]  GlyphBias  = 8'd32;
  localparam logic [6:0]  GlyphPeriod = 7'd94;

  // sgr codes
  localparam logic [6:0] SgrFgBase    = 7'd30;
  localparam logic [6:0] SgrFgDefault = 7'd39;
  localparam logic [6:0] SgrBgBase    = 7'd40;
  localparam logic [6:0] SgrBgDefault = 7'd49;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [31:0] fg;
    logic [31:0] bg;
  } tcb_cell_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic init_wr;
    logic phys_en;
    logic phys_ring;
    logic base_en;
    logic cell_wr;
    logic rd_en;
    logic res;
    logic span_init_full;
    logic span_wr;
    logic scr_wr;
    logic ring_adv;
  } tcb_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic init_last;
    logic span_done;
    logic scr_done;
    logic cnt_zero;
  } tcb_stat_t;

  // ansi palette, abgr
  function automatic logic [31:0] sgr_color(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'hFF00_0000;
      3'd1:    c = 32'hFF00_00FF;
      3'd2:    c = 32'hFF00_FF00;
      3'd3:    c = 32'hFF00_FFFF;
      3'd4:    c = 32'hFFFF_0000;
      3'd5:    c = 32'hFFFF_00FF;
      3'd6:    c = 32'hFFFF_FF00;
      default: c = 32'hFFFF_FFFF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/terminal_text_cell_buffer.sv]
// terminal_text_cell_buffer: top level of the ring-scrolled text cell store
// depends on tcb_pkg, tcb_ctrl, tcb_datapath
//
// Usage:
//   A command transfer is taken at a rising edge with start_i high and busy_o low.
//   Fields cmd_i, column_i, line_i, char_code_i, erase_mode_i, scroll_count_i and
//   sgr_code_i are sampled at that edge. Only read cell gives a result: valid_o is
//   high for exactly one cycle with glyph_o, fg_abgr_o, bg_abgr_o and read_ok_o.
//   The receiver cannot stall; the result registers hold until the next read.
//   Busy states per command after the accepting edge (states of tcb_ctrl):
//     colour commands and unused codes: none, the next command may follow at once
//     print, clear cell: SPhys, SMul, SCell; read cell: SPhys, SMul, SRd, SRes, with
//     valid_o in the cycle after SRes; erase line: SPhys, SMul, then SSpan over the cells;
//     scroll up: per row SSchk, SSmul, SSpan, SSadv, then SSchk; erase screen: SScreen
//   The single write port of the cell memory sets the sweep lengths: one cell a cycle.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write one register per edge and
//   reset the ring start to row zero; the user must write only while idle (unenforced).
//   Reset: the memory is filled with the test pattern one cell a cycle, all
//   MAX_COLUMNS*MAX_ROWS cells (8192 by default), with busy_o high.
`default_nettype none
module terminal_text_cell_buffer #(
  parameter int unsigned MAX_COLUMNS = tcb_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = tcb_pkg::MaxRowsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [6:0]  column_i,
  input  wire logic [5:0]  line_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [1:0]  erase_mode_i,
  input  wire logic [7:0]  scroll_count_i,
  input  wire logic [6:0]  sgr_code_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  output logic             valid_o,
  output logic [7:0]       glyph_o,
  output logic [31:0]      fg_abgr_o,
  output logic [31:0]      bg_abgr_o,
  output logic             read_ok_o
);

  tcb_pkg::tcb_ctrl_t ctrl;
  tcb_pkg::tcb_stat_t stat;

  // sequencer
  tcb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  // storage and arithmetic
  tcb_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .column_i       (column_i),
    .line_i         (line_i),
    .char_code_i    (char_code_i),
    .erase_mode_i   (erase_mode_i),
    .scroll_count_i (scroll_count_i),
    .sgr_code_i     (sgr_code_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .valid_o        (valid_o),
    .glyph_o        (glyph_o),
    .fg_abgr_o      (fg_abgr_o),
    .bg_abgr_o      (bg_abgr_o),
    .read_ok_o      (read_ok_o)
  );

endmodule
`default_nettype wire

[rtl/core/tcb_datapath.sv]
// tcb_datapath: cell memory, ring start, colours, sweep counters and result registers
// depends on tcb_pkg
`default_nettype none
module tcb_datapath #(
  parameter int unsigned MAX_COLUMNS = tcb_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = tcb_pkg::MaxRowsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcb_pkg::tcb_ctrl_t ctrl_i,
  output tcb_pkg::tcb_stat_t     stat_o,
  input  wire logic [3:0]        cmd_i,
  input  wire logic [6:0]        column_i,
  input  wire logic [5:0]        line_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [1:0]        erase_mode_i,
  input  wire logic [7:0]        scroll_count_i,
  input  wire logic [6:0]        sgr_code_i,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [7:0]        cfg_data_i,
  output logic                   valid_o,
  output logic [7:0]             glyph_o,
  output logic [31:0]            fg_abgr_o,
  output logic [31:0]            bg_abgr_o,
  output logic                   read_ok_o
);

  localparam int unsigned Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PTRW  = $clog2(Depth + 1);
  localparam int unsigned CW    = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  tcb_pkg::tcb_cell_t mem [Depth];

  logic [7:0]      cols_q;
  logic [6:0]      rows_q;
  logic [PW-1:0]   ring_q;
  logic [31:0]     fg_q, bg_q;
  logic [6:0]      col_q;
  logic [5:0]      line_q;
  logic [7:0]      char_q;
  logic            print_q, inrange_q;
  logic [7:0]      cnt_q;
  logic [PW-1:0]   phys_q;
  logic [AW-1:0]   base_q;
  logic [CW-1:0]   x_q, x_end_q;
  logic [PTRW-1:0] ptr_q, cells_q;
  logic [6:0]      gcnt_q;
  tcb_pkg::tcb_cell_t rdata_q;
  logic            valid_q, ok_q;
  tcb_pkg::tcb_cell_t out_q;

  logic [CW-1:0]   cols_eff;
  logic [RW-1:0]   rows_eff;
  logic [CW-1:0]   col_x;
  logic            col_in, line_in;
  logic [7:0]      psum;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  tcb_pkg::tcb_cell_t wdata, blank;

  // effective grid size, clamped
  always_comb begin
    if (cols_q == 8'd0) cols_eff = CW'(1);
    else if (32'(cols_q) > MAX_COLUMNS) cols_eff = CW'(MAX_COLUMNS);
    else cols_eff = CW'(cols_q);
    if (rows_q == 7'd0) rows_eff = RW'(1);
    else if (32'(rows_q) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
    else rows_eff = RW'(rows_q);
  end

  assign col_x   = CW'(column_i);
  assign col_in  = 32'(column_i) < 32'(cols_eff);
  assign line_in = 32'(line_i) < 32'(rows_eff);
  assign psum    = 8'(ring_q) + 8'(line_q);

  // config registers and ring start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcb_pkg::ColsReset;
      rows_q <= tcb_pkg::RowsReset;
      ring_q <= '0;
    end else if (cfg_we_i) begin
      ring_q <= '0;
      unique case (cfg_idx_i)
        tcb_pkg::CfgColumns: cols_q <= cfg_data_i;
        tcb_pkg::CfgRows:    rows_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end else if (ctrl_i.ring_adv) begin
      if (32'(ring_q) + 32'd1 >= 32'(rows_eff)) ring_q <= '0;
      else ring_q <= ring_q + PW'(1);
    end
  end

  // current colours
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcb_pkg::ColorWhite;
      bg_q <= tcb_pkg::ColorBlack;
    end else if (ctrl_i.load) begin
      unique case (cmd_i)
        tcb_pkg::CmdSetFg: begin
          if (sgr_code_i >= tcb_pkg::SgrFgBase && sgr_code_i < tcb_pkg::SgrFgBase + 7'd8)
            fg_q <= tcb_pkg::sgr_color(3'(sgr_code_i - tcb_pkg::SgrFgBase));
          else if (sgr_code_i == tcb_pkg::SgrFgDefault)
            fg_q <= tcb_pkg::ColorWhite;
        end
        tcb_pkg::CmdSetBg: begin
          if (sgr_code_i >= tcb_pkg::SgrBgBase && sgr_code_i < tcb_pkg::SgrBgBase + 7'd8)
            bg_q <= tcb_pkg::sgr_color(3'(sgr_code_i - tcb_pkg::SgrBgBase));
          else if (sgr_code_i == tcb_pkg::SgrBgDefault)
            bg_q <= tcb_pkg::ColorBlack;
        end
        tcb_pkg::CmdResetCol: begin
          fg_q <= tcb_pkg::ColorWhite;
          bg_q <= tcb_pkg::ColorBlack;
        end
        default: ;
      endcase
    end
  end

  // operand capture, address and sweep counters
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      col_q     <= column_i;
      line_q    <= line_i;
      char_q    <= char_code_i;
      print_q   <= (cmd_i == tcb_pkg::CmdPrint);
      inrange_q <= col_in && line_in;
      cnt_q     <= (32'(scroll_count_i) > 32'(rows_eff)) ? 8'(rows_eff) : scroll_count_i;
      cells_q   <= PTRW'(rows_eff) * PTRW'(cols_eff);
      x_q       <= (line_in && erase_mode_i == tcb_pkg::ModeToEnd) ? col_x : '0;
      if (!line_in) begin
        x_end_q <= '0;
      end else begin
        case (erase_mode_i)
          tcb_pkg::ModeToEnd:   x_end_q <= cols_eff;
          tcb_pkg::ModeToStart: x_end_q <= col_in ? col_x : cols_eff;
          tcb_pkg::ModeWhole:   x_end_q <= cols_eff;
          default:              x_end_q <= '0;
        endcase
      end
    end else if (ctrl_i.span_init_full) begin
      x_q     <= '0;
      x_end_q <= cols_eff;
      cnt_q   <= cnt_q - 8'd1;
    end else if (ctrl_i.span_wr) begin
      x_q <= x_q + CW'(1);
    end
    if (ctrl_i.phys_en) begin
      if (ctrl_i.phys_ring) phys_q <= ring_q;
      else if (psum >= 8'(rows_eff)) phys_q <= PW'(psum - 8'(rows_eff));
      else phys_q <= PW'(psum);
    end
    if (ctrl_i.base_en) base_q <= AW'(phys_q) * AW'(cols_eff);
  end

  // fill pointer for reset pattern and erase screen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      gcnt_q <= '0;
    end else if (ctrl_i.load) begin
      ptr_q <= '0;
    end else if (ctrl_i.init_wr || ctrl_i.scr_wr) begin
      ptr_q  <= ptr_q + PTRW'(1);
      gcnt_q <= (gcnt_q == tcb_pkg::GlyphPeriod - 7'd1) ? 7'd0 : gcnt_q + 7'd1;
    end
  end

  // write port select
  always_comb begin
    blank = '{glyph: 8'd0, fg: tcb_pkg::ColorWhite, bg: tcb_pkg::ColorBlack};
    we    = 1'b0;
    waddr = AW'(ptr_q);
    wdata = blank;
    if (ctrl_i.init_wr) begin
      we    = 1'b1;
      wdata = '{glyph: 8'(gcnt_q), fg: tcb_pkg::ColorWhite, bg: tcb_pkg::ColorBlack};
    end else if (ctrl_i.scr_wr) begin
      we = 1'b1;
    end else if (ctrl_i.cell_wr) begin
      we    = inrange_q;
      waddr = base_q + AW'(col_q);
      if (print_q)
        wdata = '{glyph: char_q - tcb_pkg::GlyphBias, fg: fg_q, bg: bg_q};
    end else if (ctrl_i.span_wr) begin
      we    = 1'b1;
      waddr = base_q + AW'(x_q);
    end
  end

  assign raddr = base_q + AW'(col_q);

  // cell memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (ctrl_i.rd_en) rdata_q <= mem[raddr];
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= ctrl_i.res;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res) begin
      ok_q  <= inrange_q;
      out_q <= inrange_q ? rdata_q : '0;
    end
  end

  assign valid_o   = valid_q;
  assign glyph_o   = out_q.glyph;
  assign fg_abgr_o = out_q.fg;
  assign bg_abgr_o = out_q.bg;
  assign read_ok_o = ok_q;

  assign stat_o.init_last = (ptr_q == PTRW'(Depth - 1));
  assign stat_o.span_done = (x_q >= x_end_q);
  assign stat_o.scr_done  = (ptr_q >= cells_q);
  assign stat_o.cnt_zero  = (cnt_q == 8'd0);

endmodule
`default_nettype wire

[rtl/core/tcb_ctrl.sv]
// tcb_ctrl: command sequencer for the text cell buffer
// depends on tcb_pkg
`default_nettype none
module tcb_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [3:0]         cmd_i,
  input  wire tcb_pkg::tcb_stat_t stat_i,
  output tcb_pkg::tcb_ctrl_t      ctrl_o,
  output logic                    busy_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SInit   = 4'd1;
  localparam logic [3:0] SPhys   = 4'd2;
  localparam logic [3:0] SMul    = 4'd3;
  localparam logic [3:0] SCell   = 4'd4;
  localparam logic [3:0] SRd     = 4'd5;
  localparam logic [3:0] SRes    = 4'd6;
  localparam logic [3:0] SSpan   = 4'd7;
  localparam logic [3:0] SSchk   = 4'd8;
  localparam logic [3:0] SSmul   = 4'd9;
  localparam logic [3:0] SSadv   = 4'd10;
  localparam logic [3:0] SScreen = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] op_q, op_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ctrl_o  = '0;
    unique case (state_q)
      SInit: begin
        ctrl_o.init_wr = 1'b1;
        if (stat_i.init_last) state_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          op_d        = cmd_i;
          unique case (cmd_i) inside
            tcb_pkg::CmdPrint, tcb_pkg::CmdClearCell,
            tcb_pkg::CmdEraseLine, tcb_pkg::CmdReadCell: state_d = SPhys;
            tcb_pkg::CmdEraseScr: state_d = SScreen;
            tcb_pkg::CmdScrollUp: state_d = SSchk;
            default: ;
          endcase
        end
      end
      SPhys: begin
        ctrl_o.phys_en = 1'b1;
        state_d        = SMul;
      end
      SMul: begin
        ctrl_o.base_en = 1'b1;
        if (op_q == tcb_pkg::CmdEraseLine) state_d = SSpan;
        else if (op_q == tcb_pkg::CmdReadCell) state_d = SRd;
        else state_d = SCell;
      end
      SCell: begin
        ctrl_o.cell_wr = 1'b1;
        state_d        = SIdle;
      end
      SRd: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = SRes;
      end
      SRes: begin
        ctrl_o.res = 1'b1;
        state_d    = SIdle;
      end
      SSpan: begin
        if (stat_i.span_done) begin
          state_d = (op_q == tcb_pkg::CmdScrollUp) ? SSadv : SIdle;
        end else begin
          ctrl_o.span_wr = 1'b1;
        end
      end
      SSchk: begin
        if (stat_i.cnt_zero) begin
          state_d = SIdle;
        end else begin
          ctrl_o.phys_en   = 1'b1;
          ctrl_o.phys_ring = 1'b1;
          state_d          = SSmul;
        end
      end
      SSmul: begin
        ctrl_o.base_en        = 1'b1;
        ctrl_o.span_init_full = 1'b1;
        state_d               = SSpan;
      end
      SSadv: begin
        ctrl_o.ring_adv = 1'b1;
        state_d         = SSchk;
      end
      SScreen: begin
        if (stat_i.scr_done) state_d = SIdle;
        else ctrl_o.scr_wr = 1'b1;
      end
      default: state_d = SIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      op_q    <= tcb_pkg::CmdPrint;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  // at most one memory writer per cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.init_wr, ctrl_o.cell_wr, ctrl_o.span_wr, ctrl_o.scr_wr}))
    else $error("several memory writers at once");

  // a read always goes on to the result cycle
  a_rd_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRd) |=> (state_q == SRes))
    else $error("read not followed by result");

  // no transfer is taken during the fill after reset
  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SInit) |-> (busy_o && !ctrl_o.load))
    else $error("load during reset fill");

  // ring only moves inside a scroll
  a_ring_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.ring_adv |-> (op_q == tcb_pkg::CmdScrollUp))
    else $error("ring advance outside scroll");

endmodule
`default_nettype wire

[bench/terminal_text_cell_buffer_tb.sv]
// terminal_text_cell_buffer_tb: self-checking regression for the ring-scrolled text cell store
// depends on tcb_pkg and terminal_text_cell_buffer; a scoreboard class mirrors the cell store
// and checks every read cell result against the predicted cell
`default_nettype none

module terminal_text_cell_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cols = 128;
  localparam int unsigned Rows = 64;
  localparam int unsigned Depth = Cols * Rows;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        ok;
  } read_res_t;

  // shadow of the cell store plus queue of pending read results
  class cell_scoreboard;
    tcb_pkg::tcb_cell_t cells[Depth];
    int unsigned ring_row;
    logic [31:0] cur_fg, cur_bg;
    logic [7:0]  reg_cols;
    logic [6:0]  reg_rows;
    read_res_t   pending_reads[$];
    int unsigned errors;

    function void init();
      for (int i = 0; i < Depth; i++) begin
        cells[i] = '{glyph: 8'(i % 94), fg: tcb_pkg::ColorWhite, bg: tcb_pkg::ColorBlack};
      end
      ring_row = 0;
      cur_fg = tcb_pkg::ColorWhite;
      cur_bg = tcb_pkg::ColorBlack;
      reg_cols = tcb_pkg::ColsReset;
      reg_rows = tcb_pkg::RowsReset;
      errors = 0;
    endfunction

    function int unsigned ncols();
      if (reg_cols == 0) return 1;
      if (reg_cols > Cols) return Cols;
      return reg_cols;
    endfunction

    function int unsigned nrows();
      if (reg_rows == 0) return 1;
      if (reg_rows > Rows) return Rows;
      return reg_rows;
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
      if (idx == tcb_pkg::CfgColumns) reg_cols = data;
      else reg_rows = data[6:0];
      ring_row = 0;
    endfunction

    function int unsigned cell_addr(int unsigned c, int unsigned r);
      int unsigned p;
      p = (ring_row % nrows()) + r;
      if (p >= nrows()) p -= nrows();
      return (c + p * ncols()) % Depth;
    endfunction

    function void blank(int unsigned c, int unsigned r);
      if (c < ncols() && r < nrows())
        cells[cell_addr(c, r)] = '{glyph: 8'd0, fg: tcb_pkg::ColorWhite,
                                   bg: tcb_pkg::ColorBlack};
    endfunction

    // note one accepted command and update the shadow state
    function void note_command(logic [3:0] cmd, logic [6:0] c, logic [5:0] r,
                               logic [7:0] ch, logic [1:0] mode, logic [7:0] cnt,
                               logic [6:0] sgr);
      int unsigned nc, nr, n, a;
      read_res_t rr;
      nc = ncols();
      nr = nrows();
      case (cmd)
        tcb_pkg::CmdPrint: begin
          if (c < nc && r < nr) begin
            a = cell_addr(c, r);
            cells[a] = '{glyph: ch - tcb_pkg::GlyphBias, fg: cur_fg, bg: cur_bg};
          end
        end
        tcb_pkg::CmdClearCell: blank(c, r);
        tcb_pkg::CmdEraseLine: begin
          if (mode == tcb_pkg::ModeToEnd)
            for (int x = c; x < nc; x++) blank(x, r);
          else if (mode == tcb_pkg::ModeToStart)
            for (int x = 0; x < c && x < nc; x++) blank(x, r);
          else if (mode == tcb_pkg::ModeWhole)
            for (int x = 0; x < nc; x++) blank(x, r);
        end
        tcb_pkg::CmdEraseScr:
          for (int y = 0; y < nr; y++) for (int x = 0; x < nc; x++) blank(x, y);
        tcb_pkg::CmdScrollUp: begin
          n = (cnt > nr) ? nr : cnt;
          ring_row = ring_row % nr;
          for (int y = 0; y < n; y++) begin
            for (int x = 0; x < nc; x++)
              cells[(x + ring_row * nc) % Depth] = '{glyph: 8'd0, fg: tcb_pkg::ColorWhite,
                                                     bg: tcb_pkg::ColorBlack};
            ring_row++;
            if (ring_row >= nr) ring_row = 0;
          end
        end
        tcb_pkg::CmdSetFg: begin
          if (sgr >= tcb_pkg::SgrFgBase && sgr <= tcb_pkg::SgrFgBase + 7)
            cur_fg = tcb_pkg::sgr_color(3'(sgr - tcb_pkg::SgrFgBase));
          else if (sgr == tcb_pkg::SgrFgDefault) cur_fg = tcb_pkg::ColorWhite;
        end
        tcb_pkg::CmdSetBg: begin
          if (sgr >= tcb_pkg::SgrBgBase && sgr <= tcb_pkg::SgrBgBase + 7)
            cur_bg = tcb_pkg::sgr_color(3'(sgr - tcb_pkg::SgrBgBase));
          else if (sgr == tcb_pkg::SgrBgDefault) cur_bg = tcb_pkg::ColorBlack;
        end
        tcb_pkg::CmdResetCol: begin
          cur_fg = tcb_pkg::ColorWhite;
          cur_bg = tcb_pkg::ColorBlack;
        end
        tcb_pkg::CmdReadCell: begin
          if (c < nc && r < nr) begin
            a = cell_addr(c, r);
            rr = '{glyph: cells[a].glyph, fg: cells[a].fg, bg: cells[a].bg, ok: 1'b1};
          end else begin
            rr = '0;
          end
          pending_reads.push_back(rr);
        end
        default: ;
      endcase
    endfunction

    // compare one read result with the oldest prediction
    function void check_read(read_res_t got, realtime t);
      read_res_t exp_r;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read result %h", t, got);
        errors++;
        return;
      end
      exp_r = pending_reads.pop_front();
      if (got.glyph !== exp_r.glyph) begin
        $display("%0t: glyph exp %h got %h", t, exp_r.glyph, got.glyph);
        errors++;
      end
      if (got.fg !== exp_r.fg) begin
        $display("%0t: fg_abgr exp %h got %h", t, exp_r.fg, got.fg);
        errors++;
      end
      if (got.bg !== exp_r.bg) begin
        $display("%0t: bg_abgr exp %h got %h", t, exp_r.bg, got.bg);
        errors++;
      end
      if (got.ok !== exp_r.ok) begin
        $display("%0t: read_ok exp %b got %b", t, exp_r.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [3:0]  cmd_i = '0;
  logic [6:0]  column_i = '0;
  logic [5:0]  line_i = '0;
  logic [7:0]  char_code_i = '0;
  logic [1:0]  erase_mode_i = '0;
  logic [7:0]  scroll_count_i = '0;
  logic [6:0]  sgr_code_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  logic        valid_o;
  logic [7:0]  glyph_o;
  logic [31:0] fg_abgr_o, bg_abgr_o;
  logic        read_ok_o;

  cell_scoreboard sb;
  longint cycle_count = 0;
  bit     idle_on = 1'b1;

  terminal_text_cell_buffer dut (.*);

  always #6 clk_i = ~clk_i;

  // result monitor and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && valid_o)
      sb.check_read('{glyph: glyph_o, fg: fg_abgr_o, bg: bg_abgr_o, ok: read_ok_o}, $realtime);
    if (cycle_count > CycleLimit) begin
      $display("terminal_text_cell_buffer regression: fail");
      $finish;
    end
  end

  // one command transfer; start stays high across back-to-back transfers
  task automatic send_cmd(logic [3:0] cmd, logic [6:0] c, logic [5:0] r, logic [7:0] ch,
                          logic [1:0] mode, logic [7:0] cnt, logic [6:0] sgr);
    while (idle_on && $urandom_range(99) < 24) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= cmd;
    column_i <= c;
    line_i <= r;
    char_code_i <= ch;
    erase_mode_i <= mode;
    scroll_count_i <= cnt;
    sgr_code_i <= sgr;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(cmd, c, r, ch, mode, cnt, sgr);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_reads.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // random command biased to hit cells inside the grid
  task automatic random_cmd();
    logic [3:0] cmd;
    logic [6:0] c;
    logic [5:0] r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) cmd = tcb_pkg::CmdPrint;
    else if (pick < 58) cmd = tcb_pkg::CmdReadCell;
    else if (pick < 62) cmd = tcb_pkg::CmdClearCell;
    else if (pick < 67) cmd = tcb_pkg::CmdEraseLine;
    else if (pick < 68) cmd = tcb_pkg::CmdEraseScr;
    else if (pick < 72) cmd = tcb_pkg::CmdScrollUp;
    else if (pick < 82) cmd = tcb_pkg::CmdSetFg;
    else if (pick < 92) cmd = tcb_pkg::CmdSetBg;
    else if (pick < 95) cmd = tcb_pkg::CmdResetCol;
    else cmd = 4'($urandom_range(15));
    if ($urandom_range(9) < 8) begin
      c = 7'($urandom_range(sb.ncols() - 1));
      r = 6'($urandom_range(sb.nrows() - 1));
    end else begin
      c = 7'($urandom);
      r = 6'($urandom);
    end
    send_cmd(cmd, c, r, 8'($urandom), 2'($urandom),
             ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4)),
             ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(28, 50)));
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset pattern, colours, extremes, erase modes, scroll
    send_cmd(tcb_pkg::CmdReadCell, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdReadCell, 7'd79, 6'd24, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdReadCell, 7'd80, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdReadCell, 7'd127, 6'd63, 8'hFF, tcb_pkg::ModeNone, 8'hFF, 7'h7F);
    send_cmd(tcb_pkg::CmdSetFg, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd31);
    send_cmd(tcb_pkg::CmdSetBg, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd47);
    send_cmd(tcb_pkg::CmdSetFg, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd38);
    send_cmd(tcb_pkg::CmdPrint, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdPrint, 7'd79, 6'd24, 8'hFF, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdPrint, 7'd5, 6'd40, 8'h41, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdReadCell, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdReadCell, 7'd79, 6'd24, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdSetFg, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0,
             tcb_pkg::SgrFgDefault);
    send_cmd(tcb_pkg::CmdSetBg, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0,
             tcb_pkg::SgrBgDefault);
    send_cmd(tcb_pkg::CmdSetBg, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd48);
    send_cmd(tcb_pkg::CmdResetCol, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdClearCell, 7'd1, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdEraseLine, 7'd40, 6'd1, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdEraseLine, 7'd40, 6'd2, 8'd0, tcb_pkg::ModeToStart, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdEraseLine, 7'd127, 6'd3, 8'd0, tcb_pkg::ModeWhole, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdEraseLine, 7'd0, 6'd4, 8'd0, tcb_pkg::ModeNone, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdScrollUp, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd3, 7'd0);
    send_cmd(tcb_pkg::CmdScrollUp, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'hFF, 7'd0);
    send_cmd(4'd15, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);
    send_cmd(tcb_pkg::CmdEraseScr, 7'd0, 6'd0, 8'd0, tcb_pkg::ModeToEnd, 8'd0, 7'd0);

    // random phases over several grid settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_cfg(tcb_pkg::CfgColumns, 8'd1);
          write_cfg(tcb_pkg::CfgRows, 8'd1);
        end
        1: begin
          write_cfg(tcb_pkg::CfgColumns, 8'd128);
          write_cfg(tcb_pkg::CfgRows, 8'd64);
        end
        2: begin
          write_cfg(tcb_pkg::CfgColumns, 8'd0);
          write_cfg(tcb_pkg::CfgRows, 8'd0);
        end
        3: begin
          write_cfg(tcb_pkg::CfgColumns, 8'd255);
          write_cfg(tcb_pkg::CfgRows, 8'd127);
        end
        default: begin
          write_cfg(tcb_pkg::CfgColumns, 8'($urandom_range(1, 40)));
          write_cfg(tcb_pkg::CfgRows, 8'($urandom_range(1, 20)));
        end
      endcase
      idle_on = (ph != 4);
      for (int i = 0; i < 200; i++) begin
        random_cmd();
        if (i == 100 && ph == 5) drain();
      end
    end

    drain();
    if (sb.errors == 0) $display("terminal_text_cell_buffer regression: pass");
    else $display("terminal_text_cell_buffer regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

[terminal_text_cell_buffer.f]
rtl/core/tcb_pkg.sv
rtl/core/tcb_datapath.sv
rtl/core/tcb_ctrl.sv
rtl/core/terminal_text_cell_buffer.sv
bench/terminal_text_cell_buffer_tb.sv
